FILE: rtl/battery_voltage_filter_soc_defines.svh
// ----------------------------------------------------------------------------
// Battery voltage filter assertion macros
// Concurrent checks on clk_i; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_FILTER_SOC_DEFINES_SVH
`define BATTERY_VOLTAGE_FILTER_SOC_DEFINES_SVH

`ifndef SYNTHESIS
// Check that is ignored while reset is asserted.
`define BVF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Check that holds through reset as well.
`define BVF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BVF_ASSERT(name, prop, msg)
`define BVF_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

FILE: rtl/bvf_pkg.sv
// ----------------------------------------------------------------------------
// bvf_pkg
// Shared widths, discharge curve table and types of the battery voltage filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bvf_pkg;

  // Field widths
  localparam int unsigned ADC_W     = 12;
  localparam int unsigned MON_W     = 15;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned OFFSET_W  = 12;
  localparam int unsigned ALPHA_W   = 16;
  localparam int unsigned FMV_W     = 15;
  localparam int unsigned PCT_W     = 7;

  // Fixed point: millivolts with 8 fraction bits
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned LEVEL_W   = 24;
  localparam int unsigned READING_W = 23;
  localparam int unsigned RAW_W     = 26;
  localparam int unsigned SCALE_SHIFT = 4;  // Q4.12 times mV -> mV Q.8

  localparam logic [MON_W-1:0]     MON_MIN_MV  = 15'd1000;
  localparam logic signed [RAW_W-1:0] WIN_LOW_Q8  = 26'sd256000;
  localparam logic signed [RAW_W-1:0] WIN_HIGH_Q8 = 26'sd5120000;
  localparam logic [PCT_W-1:0]     PCT_MAX     = 7'd100;

  // Register reset values
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd16384;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 12'd0;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd3277;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_SCALE  = 2'd0,
    REG_OFFSET = 2'd1,
    REG_ALPHA  = 2'd2
  } reg_idx_e;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // 3S Li-ion discharge curve, descending voltage
  localparam int unsigned CURVE_POINTS = 14;
  localparam int unsigned PT_W  = $clog2(CURVE_POINTS);
  localparam int unsigned MV_W  = 14;
  localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    14'd12600, 14'd12450, 14'd12300, 14'd12150, 14'd12000, 14'd11800, 14'd11600,
    14'd11400, 14'd11200, 14'd11000, 14'd10800, 14'd10500, 14'd10200, 14'd9900
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd95, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40,  7'd30, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
  };

  // Segment arithmetic bounds for this curve
  localparam int unsigned SPAN_W = 9;   // widest segment: 300 mV
  localparam int unsigned DP_W   = 4;   // largest step: 10 %
  localparam int unsigned QUO_W  = 4;   // quotient never exceeds the step
  localparam int unsigned OFF_W  = SPAN_W + FRAC_W;
  localparam int unsigned NUM_W  = OFF_W + DP_W;
  localparam int unsigned DEN_W  = OFF_W + QUO_W - 1;

  typedef struct packed {
    logic                 accepted;
    logic                 used_monitor;
    logic [READING_W-1:0] reading;
  } reading_t;

  typedef struct packed {
    logic [SCALE_W-1:0]         scale;
    logic signed [OFFSET_W-1:0] offset;
    logic [ALPHA_W-1:0]         alpha;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/bvf_front.sv
// ----------------------------------------------------------------------------
// bvf_front
// Input stage: picks the voltage source, scales the ADC value, window check.
// ----------------------------------------------------------------------------
`default_nettype none

module bvf_front import bvf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ADC_W-1:0] adc_millivolts_i,
  input  wire logic             monitor_valid_i,
  input  wire logic [MON_W-1:0] monitor_millivolts_i,
  input  wire cfg_t             cfg_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output reading_t              q_data_o
);

  localparam int unsigned PROD_W = ADC_W + SCALE_W;
  localparam int unsigned SC_W   = PROD_W - SCALE_SHIFT;

  logic             hold_valid_q, hold_valid_d;
  logic [ADC_W-1:0] adc_q;
  logic             mvalid_q;
  logic [MON_W-1:0] mon_q;
  logic             accept;

  logic [PROD_W-1:0]       scaled_full;
  logic signed [RAW_W-1:0] adc_raw;
  logic signed [RAW_W-1:0] mon_raw;
  logic signed [RAW_W-1:0] raw;
  logic                    use_mon;

  assign in_stall_o   = hold_valid_q & q_full_i;
  assign accept       = in_valid_i & ~in_stall_o;
  assign q_push_o     = hold_valid_q & ~q_full_i;
  assign hold_valid_d = accept | (hold_valid_q & ~q_push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      adc_q    <= adc_millivolts_i;
      mvalid_q <= monitor_valid_i;
      mon_q    <= monitor_millivolts_i;
    end
  end

  // Q4.12 ratio times mV, floored into mV Q.8, then the offset
  assign scaled_full = adc_q * cfg_i.scale;
  assign adc_raw = $signed({{(RAW_W-SC_W){1'b0}}, scaled_full[PROD_W-1:SCALE_SHIFT]})
                 + (RAW_W'(cfg_i.offset) <<< FRAC_W);
  assign mon_raw = $signed({{(RAW_W-MON_W-FRAC_W){1'b0}}, mon_q, {FRAC_W{1'b0}}});

  assign use_mon = mvalid_q & (mon_q > MON_MIN_MV);
  assign raw     = use_mon ? mon_raw : adc_raw;

  assign q_data_o.accepted     = (raw >= WIN_LOW_Q8) && (raw <= WIN_HIGH_Q8);
  assign q_data_o.used_monitor = use_mon;
  assign q_data_o.reading      = raw[READING_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/bvf_queue.sv
// ----------------------------------------------------------------------------
// bvf_queue
// Small FIFO of classified readings between the front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_voltage_filter_soc_defines.svh"

module bvf_queue import bvf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire reading_t data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output reading_t      data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  reading_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `BVF_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue count above depth")
  `BVF_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full queue")
  `BVF_ASSERT(a_no_underflow, pop_i |-> valid_o, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/bvf_back.sv
// ----------------------------------------------------------------------------
// bvf_back
// Sequencer: EMA update, curve segment lookup, interpolation and result reg.
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_voltage_filter_soc_defines.svh"

module bvf_back import bvf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire reading_t          q_data_i,
  output logic                   q_pop_o,
  input  wire cfg_t              cfg_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   reading_accepted_o,
  output logic                   used_monitor_o,
  output logic [FMV_W-1:0]       filtered_millivolts_o,
  output logic [PCT_W-1:0]       charge_percent_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_SEG   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam int unsigned DIFF_W = LEVEL_W + 2;
  localparam int unsigned PROD_W = DIFF_W + ALPHA_W + 1;
  localparam int unsigned SUM_W  = PROD_W - ALPHA_W;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  logic [2:0]          state_q, state_d;
  logic [LEVEL_W-1:0]  f_q, f_d;
  logic [PCT_W-1:0]    pct_q, pct_d;
  logic                out_valid_q, out_valid_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_load;

  reading_t                 item_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [OFF_W-1:0]         off_q;
  logic [SPAN_W-1:0]        span_q;
  logic [DP_W-1:0]          dp_q;
  logic [PCT_W-1:0]         base_q;
  logic [NUM_W-1:0]         rem_q;
  logic [DEN_W-1:0]         den_q;
  logic [QUO_W-1:0]         quo_q;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  f_sum;
  logic [PT_W-1:0]          seg, seg_lo;
  logic [LEVEL_W-1:0]       lvl_off;
  logic                     at_top, at_bottom;
  logic [NUM_W-1:0]         num;
  logic                     ge;
  logic [NUM_W-1:0]         rem_nxt;
  logic [QUO_W-1:0]         quo_nxt;

  // f + ((r - f) * alpha) >>> 16 equals the two-term weighted sum, floored
  assign diff  = $signed({2'b00, 1'b0, item_q.reading}) - $signed({2'b00, f_q});
  assign prod  = diff * $signed({1'b0, cfg_i.alpha});
  assign f_sum = $signed({{(SUM_W-LEVEL_W){1'b0}}, f_q}) + prod_q[PROD_W-1:ALPHA_W];

  // Curve segment: first one from the top whose low end is at or below f
  always_comb begin
    seg = '0;
    for (int i = CURVE_POINTS - 2; i >= 0; i--) begin
      if (f_q >= LEVEL_W'({CURVE_MV[i+1], {FRAC_W{1'b0}}})) begin
        seg = PT_W'(i);
      end
    end
  end

  assign seg_lo    = seg + PT_W'(1);
  assign lvl_off   = f_q - LEVEL_W'({CURVE_MV[seg_lo], {FRAC_W{1'b0}}});
  assign at_top    = f_q >= LEVEL_W'({CURVE_MV[0], {FRAC_W{1'b0}}});
  assign at_bottom = f_q <= LEVEL_W'({CURVE_MV[CURVE_POINTS-1], {FRAC_W{1'b0}}});
  assign num       = off_q * dp_q;

  // Restoring divide, one quotient bit per cycle
  assign ge      = NUM_W'(den_q) <= rem_q;
  assign rem_nxt = ge ? rem_q - NUM_W'(den_q) : rem_q;
  assign quo_nxt = {quo_q[QUO_W-2:0], ge};

  always_comb begin
    state_d     = state_q;
    f_d         = f_q;
    pct_d       = pct_q;
    step_d      = step_q;
    out_valid_d = out_valid_q & out_stall_i;
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = q_data_i.accepted ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: state_d = ST_ADD;
      ST_ADD: begin
        f_d     = f_sum[LEVEL_W-1:0];
        state_d = ST_SEG;
      end
      ST_SEG: begin
        if (at_top) begin
          pct_d   = PCT_MAX;
          state_d = ST_OUT;
        end else if (at_bottom) begin
          pct_d   = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        step_d  = STEP_W'(QUO_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          pct_d   = base_q + PCT_W'(quo_nxt);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      f_q         <= '0;
      pct_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      f_q         <= f_d;
      pct_q       <= pct_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_data_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod;
    end
    if (state_q == ST_SEG) begin
      off_q  <= lvl_off[OFF_W-1:0];
      span_q <= SPAN_W'(CURVE_MV[seg] - CURVE_MV[seg_lo]);
      dp_q   <= DP_W'(CURVE_PCT[seg] - CURVE_PCT[seg_lo]);
      base_q <= CURVE_PCT[seg_lo];
    end
    if (state_q == ST_SCALE) begin
      rem_q <= num;
      den_q <= {span_q, {FRAC_W{1'b0}}, {(QUO_W-1){1'b0}}};
      quo_q <= '0;
    end
    if (state_q == ST_DIV) begin
      rem_q <= rem_nxt;
      den_q <= den_q >> 1;
      quo_q <= quo_nxt;
    end
    if (out_load) begin
      reading_accepted_o    <= item_q.accepted;
      used_monitor_o        <= item_q.used_monitor;
      filtered_millivolts_o <= f_q[FRAC_W+FMV_W-1:FRAC_W];
      charge_percent_o      <= pct_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `BVF_ASSERT(a_pct_range, pct_q <= PCT_MAX, "charge percent above 100")
  `BVF_ASSERT(a_level_range, f_q[LEVEL_W-1] == 1'b0, "filter level out of range")
  `BVF_ASSERT(a_div_nonzero, (state_q == ST_DIV) |-> (den_q != '0), "zero divisor step")

endmodule

`default_nettype wire

FILE: rtl/battery_voltage_filter_soc.sv
// ----------------------------------------------------------------------------
// battery_voltage_filter_soc
// Battery voltage EMA filter with piecewise-linear state-of-charge mapping.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one request per reading with the
//    ADC millivolts and optional monitor voltage. Accepted on a clock edge with
//    valid high and stall low.
//  - Output channel (out_valid_o / out_stall_i): exactly one result per
//    request, in order: window pass flag, selected source, filtered mV and
//    charge percent. The result register holds while out_stall_i is high.
//  - APB port sets divider scale (0x0), divider offset (0x4), EMA alpha (0x8).
//    Write only while the block is idle.
//  - A rejected reading skips the EMA update, curve lookup and quotient loop.
//  - The back-end sequencer handles one reading at a time: one shared EMA
//    multiply, a curve lookup and a 4-step quotient loop.
//  - A 2-entry queue lets the front take new requests while the back works;
//    with the output stalled the queue fills and then in_stall_o rises.
//  - Reset: filter level and percent clear to zero, registers take defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_voltage_filter_soc import bvf_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ADC_W-1:0]  adc_millivolts_i,
  input  wire logic              monitor_valid_i,
  input  wire logic [MON_W-1:0]  monitor_millivolts_i,
  // Output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   reading_accepted_o,
  output logic                   used_monitor_o,
  output logic [FMV_W-1:0]       filtered_millivolts_o,
  output logic [PCT_W-1:0]       charge_percent_o,
  // APB configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Configuration registers
  logic [SCALE_W-1:0]  scale_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [ALPHA_W-1:0]  alpha_q;
  logic                wr_en;
  cfg_t                cfg;

  // Front to queue to back
  logic     push, q_full, q_valid, pop;
  reading_t push_data, pop_data;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_RST;
      offset_q <= OFFSET_RST;
      alpha_q  <= ALPHA_RST;
    end else if (wr_en) begin
      // word index in paddr[3:2]; unmapped index is dropped
      unique case (paddr[3:2])
        REG_SCALE:  scale_q  <= pwdata[SCALE_W-1:0];
        REG_OFFSET: offset_q <= pwdata[OFFSET_W-1:0];
        REG_ALPHA:  alpha_q  <= pwdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SCALE:  prdata = {{(32-SCALE_W){1'b0}}, scale_q};
      REG_OFFSET: prdata = {{(32-OFFSET_W){1'b0}}, offset_q};
      REG_ALPHA:  prdata = {{(32-ALPHA_W){1'b0}}, alpha_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg.scale  = scale_q;
  assign cfg.offset = $signed(offset_q);
  assign cfg.alpha  = alpha_q;

  // Source select, scaling and window check
  bvf_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .adc_millivolts_i     (adc_millivolts_i),
    .monitor_valid_i      (monitor_valid_i),
    .monitor_millivolts_i (monitor_millivolts_i),
    .cfg_i                (cfg),
    .q_full_i             (q_full),
    .q_push_o             (push),
    .q_data_o             (push_data)
  );

  bvf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_data)
  );

  // Filter update, percent mapping and result register
  bvf_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .q_valid_i             (q_valid),
    .q_data_i              (pop_data),
    .q_pop_o               (pop),
    .cfg_i                 (cfg),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .reading_accepted_o    (reading_accepted_o),
    .used_monitor_o        (used_monitor_o),
    .filtered_millivolts_o (filtered_millivolts_o),
    .charge_percent_o      (charge_percent_o)
  );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Battery voltage filter testbench
// Sends requests of ADC and monitor voltages through the valid/stall channel,
// rewrites the divider and filter registers over APB between phases, and
// checks every result against a cycle-free model of the filter and the
// charge curve. The model keeps its own filter level and register copies.
// ----------------------------------------------------------------------------
module tb;
  import bvf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES      = 8;
  localparam int RANDOM_REQS = 174;   // per phase
  localparam int SETTLE      = 12;    // covers the slowest accept-to-result path
  localparam int CYCLE_LIMIT = 400000;

  // Sanity window on the selected reading, mV with 8 fraction bits
  localparam longint WINDOW_LO_Q8 = 1000 * 256;
  localparam longint WINDOW_HI_Q8 = 20000 * 256;
  localparam longint MONITOR_FLOOR = 1000;

  // 3S Li-ion discharge curve, knees from full down to empty
  localparam int KNEES = 14;
  localparam int KNEE_MV  [KNEES] = '{12600, 12450, 12300, 12150, 12000, 11800,
                                      11600, 11400, 11200, 11000, 10800, 10500,
                                      10200, 9900};
  localparam int KNEE_PCT [KNEES] = '{100, 95, 90, 80, 70, 60, 50, 40, 30, 20,
                                      15, 10, 5, 0};

  typedef struct packed {
    logic             accepted;
    logic             used_monitor;
    logic [FMV_W-1:0] millivolts;
    logic [PCT_W-1:0] percent;
  } soc_result_t;

  // One row of the directed table; "typed" rows carry a hand-written result
  typedef struct packed {
    logic [ADC_W-1:0] adc;
    logic             mvalid;
    logic [MON_W-1:0] mon;
    logic             typed;
    soc_result_t      want;
  } probe_row_t;

  localparam int PROBES = 14;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals
  // --------------------------------------------------------------------------
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ADC_W-1:0]  adc_millivolts_i = '0;
  logic              monitor_valid_i = 1'b0;
  logic [MON_W-1:0]  monitor_millivolts_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              reading_accepted_o;
  logic              used_monitor_o;
  logic [FMV_W-1:0]  filtered_millivolts_o;
  logic [PCT_W-1:0]  charge_percent_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  always #4 clk_i = ~clk_i;

  battery_voltage_filter_soc dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .adc_millivolts_i      (adc_millivolts_i),
    .monitor_valid_i       (monitor_valid_i),
    .monitor_millivolts_i  (monitor_millivolts_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .reading_accepted_o    (reading_accepted_o),
    .used_monitor_o        (used_monitor_o),
    .filtered_millivolts_o (filtered_millivolts_o),
    .charge_percent_o      (charge_percent_o),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // --------------------------------------------------------------------------
  // Filter model state: register copies, filter level (Q.8 mV), last percent
  // --------------------------------------------------------------------------
  logic [SCALE_W-1:0]         cfg_scale  = SCALE_RST;
  logic signed [OFFSET_W-1:0] cfg_offset = OFFSET_RST;
  logic [ALPHA_W-1:0]         cfg_alpha  = ALPHA_RST;
  logic [LEVEL_W-1:0]         level_q8   = '0;
  logic [PCT_W-1:0]           soc_pct    = '0;

  soc_result_t pending_results [$];   // one per accepted request, oldest first
  int          fault_count = 0;
  int          gap_pct  = 0;          // chance the sender idles a cycle
  int          hold_pct = 0;          // chance the receiver stalls a cycle

  // Piecewise-linear charge curve; truncating interpolation, clamped ends.
  function automatic logic [PCT_W-1:0] percent_of_level(logic [LEVEL_W-1:0] lvl);
    longint v, hi, lo, p;
    logic   found;
    logic [PCT_W-1:0] pct;
    v     = longint'(lvl);
    found = 1'b0;
    pct   = '0;
    if (v >= longint'(KNEE_MV[0]) * 256) begin
      pct = 7'd100;
    end else if (v > longint'(KNEE_MV[KNEES-1]) * 256) begin
      // first segment from the top that holds v; a knee matches the upper one
      for (int i = 0; i < KNEES - 1; i++) begin
        hi = longint'(KNEE_MV[i]) * 256;
        lo = longint'(KNEE_MV[i+1]) * 256;
        if (!found && v >= lo && v <= hi) begin
          found = 1'b1;
          p = KNEE_PCT[i+1] + ((v - lo) * (KNEE_PCT[i] - KNEE_PCT[i+1])) / (hi - lo);
          pct = PCT_W'(p);
        end
      end
    end
    return pct;
  endfunction

  // Advances the model by one request and returns the result it should give.
  function automatic soc_result_t step_soc(logic [ADC_W-1:0] adc, logic mvalid,
                                           logic [MON_W-1:0] mon);
    soc_result_t r;
    longint      reading, acc;
    logic        use_mon;
    use_mon = mvalid && (longint'(mon) > MONITOR_FLOOR);
    if (use_mon) begin
      reading = longint'(mon) * 256;
    end else begin
      // Q4.12 ratio times mV gives Q.12; shift down to Q.8 (floors)
      reading = ((longint'(adc) * longint'(cfg_scale)) >>> SCALE_SHIFT)
              + longint'(cfg_offset) * 256;
    end
    r.accepted = (reading >= WINDOW_LO_Q8) && (reading <= WINDOW_HI_Q8);
    if (r.accepted) begin
      acc = longint'(level_q8) * (65536 - longint'(cfg_alpha))
          + reading * longint'(cfg_alpha);
      level_q8 = LEVEL_W'(acc >>> 16);
      soc_pct  = percent_of_level(level_q8);
    end
    r.used_monitor = use_mon;
    r.millivolts   = level_q8[FRAC_W +: FMV_W];
    r.percent      = soc_pct;
    return r;
  endfunction

  // Random request: mostly monitor voltages on the curve and around the
  // window and monitor thresholds, the rest raw ADC readings.
  function automatic void pick_request(output logic [ADC_W-1:0] adc,
                                       output logic mvalid,
                                       output logic [MON_W-1:0] mon);
    int kind;
    kind   = $urandom_range(0, 99);
    adc    = ADC_W'($urandom);
    mon    = MON_W'($urandom);
    mvalid = 1'b1;
    if (kind < 30)      mon = MON_W'($urandom_range(9500, 13000));
    else if (kind < 45) mon = mon;
    else if (kind < 52) mon = MON_W'($urandom_range(990, 1010));
    else if (kind < 60) mon = MON_W'($urandom_range(19990, 20010));
    else if (kind < 70) mon = MON_W'($urandom_range(0, 1000));
    else                mvalid = 1'b0;
  endfunction

  task automatic flag_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
      fault_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: random idle cycles, then hold the request until it is taken.
  // Called in a clock-edge time step; returns in the step of acceptance.
  // --------------------------------------------------------------------------
  task automatic offer_request(input logic [ADC_W-1:0] adc, input logic mvalid,
                               input logic [MON_W-1:0] mon);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    adc_millivolts_i     <= adc;
    monitor_valid_i      <= mvalid;
    monitor_millivolts_i <= mon;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // APB write: setup cycle, then access until pready; updates the model copy.
  task automatic write_register(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SCALE:  cfg_scale  = value[SCALE_W-1:0];
      REG_OFFSET: cfg_offset = value[OFFSET_W-1:0];
      REG_ALPHA:  cfg_alpha  = value[ALPHA_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: check each taken result against the oldest expectation, then
  // pick the stall for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    soc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: expected no result, actual %0d %0d %0d %0d", $time,
                 reading_accepted_o, used_monitor_o, filtered_millivolts_o,
                 charge_percent_o);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        flag_field("reading_accepted", want.accepted, reading_accepted_o);
        flag_field("used_monitor", want.used_monitor, used_monitor_o);
        flag_field("filtered_millivolts", want.millivolts, filtered_millivolts_o);
        flag_field("charge_percent", want.percent, charge_percent_o);
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < hold_pct);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("battery_voltage_filter_soc: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Directed table, run on reset values. The first rows start from an empty
  // filter, so the result is typed in; the rest go through the model.
  probe_row_t probes [PROBES] = '{
    '{12'd0,    1'b0, 15'd0,     1'b1, '{1'b0, 1'b0, 15'd0, 7'd0}}, // all zero
    '{12'd0,    1'b1, 15'd1000,  1'b1, '{1'b0, 1'b0, 15'd0, 7'd0}}, // monitor at floor
    '{12'd0,    1'b1, 15'd32767, 1'b1, '{1'b0, 1'b1, 15'd0, 7'd0}}, // monitor too high
    '{12'd249,  1'b0, 15'd0,     1'b1, '{1'b0, 1'b0, 15'd0, 7'd0}}, // 996 mV, too low
    '{12'd250,  1'b0, 15'd0,     1'b0, '0},                        // window floor
    '{12'd4095, 1'b0, 15'd32767, 1'b0, '0},                        // monitor ignored
    '{12'd4095, 1'b1, 15'd1000,  1'b0, '0},
    '{12'd0,    1'b1, 15'd1001,  1'b0, '0},                        // just above floor
    '{12'd0,    1'b1, 15'd20000, 1'b0, '0},                        // window ceiling
    '{12'd4095, 1'b1, 15'd20001, 1'b0, '0},                        // rejected, holds
    '{12'hAAA,  1'b1, 15'h5555,  1'b0, '0},
    '{12'h555,  1'b0, 15'h2AAA,  1'b0, '0},
    '{12'd0,    1'b1, 15'd12600, 1'b0, '0},                        // full knee
    '{12'd0,    1'b1, 15'd9900,  1'b0, '0}                         // empty knee
  };

  // Register settings per phase; phase 0 keeps reset values, phase 5 is random
  int phase_scale  [PHASES] = '{16384, 65535, 0,    4096, 20000, 0, 12288, 16384};
  int phase_offset [PHASES] = '{0,     -2048, 2047, -2000, 2000, 0, 0,     0};
  int phase_alpha  [PHASES] = '{3277,  65535, 0,    1,    32768, 1, 65535, 3277};

  initial begin : stimulus
    logic [ADC_W-1:0] adc;
    logic             mvalid;
    logic [MON_W-1:0] mon;
    soc_result_t      predicted;

    phase_scale[5]  = $urandom_range(0, 65535);
    phase_offset[5] = int'($urandom_range(0, 4095)) - 2048;
    phase_alpha[5]  = $urandom_range(1, 65535);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < PHASES; ph++) begin
      // first a third with both sides idling, then swapped, then flat out
      gap_pct  <= (ph < 3) ? 37 : (ph < 6) ? 53 : 0;
      hold_pct <= (ph < 3) ? 53 : (ph < 6) ? 37 : 0;

      if (ph != 0) begin
        // block is idle: all results in, plus the longest pipeline time
        while (pending_results.size() != 0) @(posedge clk_i);
        repeat (SETTLE) @(posedge clk_i);
        write_register(REG_SCALE,  32'(phase_scale[ph]));
        write_register(REG_OFFSET, 32'(phase_offset[ph]));
        write_register(REG_ALPHA,  32'(phase_alpha[ph]));
      end else begin
        for (int k = 0; k < PROBES; k++) begin
          offer_request(probes[k].adc, probes[k].mvalid, probes[k].mon);
          predicted = step_soc(probes[k].adc, probes[k].mvalid, probes[k].mon);
          pending_results.push_back(probes[k].typed ? probes[k].want : predicted);
        end
      end

      for (int k = 0; k < RANDOM_REQS; k++) begin
        pick_request(adc, mvalid, mon);
        offer_request(adc, mvalid, mon);
        pending_results.push_back(step_soc(adc, mvalid, mon));
      end
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end

    // drain, then give stray results a chance to show up
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE + 4) @(posedge clk_i);
    if (fault_count == 0)
      $display("battery_voltage_filter_soc: match");
    else
      $display("battery_voltage_filter_soc: mismatch");
    $finish;
  end

endmodule
